### sv/eis_pkg.sv
// Shared types, codes and helper functions of the exposure interlock sequencer.
package eis_pkg;

    // Default width of the millisecond time base.
    localparam int unsigned TimeWidthDefault = 32;

    // Field widths.
    localparam int unsigned OpWidth    = 3;
    localparam int unsigned ExamWidth  = 3;
    localparam int unsigned RespWidth  = 3;
    localparam int unsigned CmdWidth   = 2;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned MsWidth    = 16;
    localparam int unsigned CfgIdxWidth = 2;

    // Operation codes of an input item.
    localparam logic [OpWidth-1:0] OP_TICK       = 3'd0;
    localparam logic [OpWidth-1:0] OP_BUTTON     = 3'd1;
    localparam logic [OpWidth-1:0] OP_CONNECT    = 3'd2;
    localparam logic [OpWidth-1:0] OP_DISCONNECT = 3'd3;
    localparam logic [OpWidth-1:0] OP_EXAM       = 3'd4;
    localparam logic [OpWidth-1:0] OP_STATUS     = 3'd5;

    // Exam codes.
    localparam logic [ExamWidth-1:0] EXAM_FLUORO = 3'd3;
    localparam logic [ExamWidth-1:0] EXAM_NONE   = 3'd4;

    // Button identifiers and levels.
    localparam logic BTN_PREPARE  = 1'b0;
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // Host responses.
    localparam logic [RespWidth-1:0] RESP_NONE    = 3'd0;
    localparam logic [RespWidth-1:0] RESP_CONNECT = 3'd1;
    localparam logic [RespWidth-1:0] RESP_ACK     = 3'd2;
    localparam logic [RespWidth-1:0] RESP_NACK    = 3'd3;
    localparam logic [RespWidth-1:0] RESP_DOSE    = 3'd4;

    // Device commands.
    localparam logic [CmdWidth-1:0] CMD_NONE      = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_ARM       = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_DISARM    = 2'd2;
    localparam logic [CmdWidth-1:0] CMD_WRITE_EXAM = 2'd3;

    // External phase codes.
    localparam logic [PhaseWidth-1:0] PHASE_NC      = 3'd0;
    localparam logic [PhaseWidth-1:0] PHASE_IDLE    = 3'd1;
    localparam logic [PhaseWidth-1:0] PHASE_PREPING = 3'd2;
    localparam logic [PhaseWidth-1:0] PHASE_PREPD   = 3'd3;
    localparam logic [PhaseWidth-1:0] PHASE_ACQ     = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_MASK     = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_VALUE    = 2'd3;

    // Configuration reset values.
    localparam logic [MsWidth-1:0]   DEBOUNCE_RESET = 16'd50;
    localparam logic [MsWidth-1:0]   TIMEOUT_RESET  = 16'd5000;
    localparam logic [ByteWidth-1:0] MASK_RESET     = 8'd15;
    localparam logic [ByteWidth-1:0] VALUE_RESET    = 8'd2;

    // Sequencer state, one-hot.
    typedef enum logic [4:0] {
        PH_NC      = 5'b00001,
        PH_IDLE    = 5'b00010,
        PH_PREPING = 5'b00100,
        PH_PREPD   = 5'b01000,
        PH_ACQ     = 5'b10000
    } t_phase;

    // Debounced button event.
    typedef enum logic [1:0] {
        BEV_NONE     = 2'd0,
        BEV_PRESS    = 2'd1,
        BEV_RELEASE  = 2'd2
    } t_bev;

    // One input item.
    typedef struct packed {
        logic [OpWidth-1:0]   operation;
        logic                 button_id;
        logic                 button_level;
        logic [ExamWidth-1:0] exam_code;
        logic [ByteWidth-1:0] geo_status;
        logic [ByteWidth-1:0] xray_status;
        logic [ByteWidth-1:0] dose_reading;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [RespWidth-1:0]  host_response;
        logic [ByteWidth-1:0]  dose_out;
        logic [CmdWidth-1:0]   device_command;
        logic [ExamWidth-1:0]  exam_type_out;
        logic                  exposure_enable;
        logic                  led_idle;
        logic                  led_prepared;
        logic                  led_acquiring;
        logic [PhaseWidth-1:0] phase;
    } t_result;

    // Configuration register set.
    typedef struct packed {
        logic [MsWidth-1:0]   debounce_ms;
        logic [MsWidth-1:0]   prep_limit_ms;
        logic [ByteWidth-1:0] ready_mask;
        logic [ByteWidth-1:0] ready_value;
    } t_cfg;

    // Map the one-hot state to its external phase code.
    function automatic logic [PhaseWidth-1:0] phase_code(input t_phase ph);
        logic [PhaseWidth-1:0] code;
        unique case (ph)
            PH_NC:      code = PHASE_NC;
            PH_IDLE:    code = PHASE_IDLE;
            PH_PREPING: code = PHASE_PREPING;
            PH_PREPD:   code = PHASE_PREPD;
            PH_ACQ:     code = PHASE_ACQ;
            default:    code = PHASE_NC;
        endcase
        return code;
    endfunction

endpackage

### sv/eis_core.sv
// Sequencer state and the single-step update that turns one item into one result.
module eis_core #(
    parameter int unsigned TIME_WIDTH = eis_pkg::TimeWidthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  eis_pkg::t_item  i_item,
    input  eis_pkg::t_cfg   i_cfg,
    output eis_pkg::t_result o_result
);

    // Sequencer state.
    eis_pkg::t_phase                   r_phase, n_phase;
    logic [eis_pkg::ExamWidth-1:0]     r_exam, n_exam;
    logic [TIME_WIDTH-1:0]             r_ms, n_ms;
    logic [TIME_WIDTH-1:0]             r_pstart, n_pstart;
    logic [1:0][TIME_WIDTH-1:0]        r_last, n_last;
    logic [1:0]                        r_stable, n_stable;
    logic [eis_pkg::ByteWidth-1:0]     r_dose, n_dose;
    logic                              r_en, n_en;

    // Step scratch values.
    logic [TIME_WIDTH-1:0]             btn_elapsed;
    logic [TIME_WIDTH-1:0]             prep_elapsed;
    logic [TIME_WIDTH-1:0]             debounce_ext;
    logic [TIME_WIDTH-1:0]             timeout_ext;
    logic                              geo_ready;
    logic                              xray_ready;
    eis_pkg::t_bev                     bev;
    logic [eis_pkg::RespWidth-1:0]     resp;
    logic [eis_pkg::ByteWidth-1:0]     dose_o;
    logic [eis_pkg::CmdWidth-1:0]      cmd;

    assign debounce_ext = {{(TIME_WIDTH-eis_pkg::MsWidth){1'b0}}, i_cfg.debounce_ms};
    assign timeout_ext  = {{(TIME_WIDTH-eis_pkg::MsWidth){1'b0}}, i_cfg.prep_limit_ms};
    assign btn_elapsed  = r_ms - r_last[i_item.button_id];
    assign prep_elapsed = r_ms - r_pstart;
    assign geo_ready    = (i_item.geo_status & i_cfg.ready_mask) == i_cfg.ready_value;
    assign xray_ready   = (i_item.xray_status & i_cfg.ready_mask) == i_cfg.ready_value;

    // Next state and result of the item in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_exam   = r_exam;
        n_ms     = r_ms;
        n_pstart = r_pstart;
        n_last   = r_last;
        n_stable = r_stable;
        n_dose   = r_dose;
        n_en     = r_en;
        bev      = eis_pkg::BEV_NONE;
        resp     = eis_pkg::RESP_NONE;
        dose_o   = '0;
        cmd      = eis_pkg::CMD_NONE;

        unique case (i_item.operation)
            eis_pkg::OP_TICK: begin
                n_ms = r_ms + TIME_WIDTH'(1);
            end
            eis_pkg::OP_BUTTON: begin
                // Debounce: accept a sample only once the window has passed.
                if (btn_elapsed > debounce_ext) begin
                    n_last[i_item.button_id] = r_ms;
                    if (i_item.button_level == eis_pkg::LVL_PRESSED &&
                        r_stable[i_item.button_id] == eis_pkg::LVL_RELEASED) begin
                        n_stable[i_item.button_id] = eis_pkg::LVL_PRESSED;
                        bev = eis_pkg::BEV_PRESS;
                    end else if (i_item.button_level == eis_pkg::LVL_RELEASED &&
                                 r_stable[i_item.button_id] == eis_pkg::LVL_PRESSED) begin
                        n_stable[i_item.button_id] = eis_pkg::LVL_RELEASED;
                        bev = eis_pkg::BEV_RELEASE;
                    end
                end
            end
            eis_pkg::OP_CONNECT: begin
                if (r_phase == eis_pkg::PH_NC) begin
                    resp    = eis_pkg::RESP_CONNECT;
                    n_phase = eis_pkg::PH_IDLE;
                end
            end
            eis_pkg::OP_DISCONNECT: begin
                if (r_phase != eis_pkg::PH_NC) begin
                    n_en    = 1'b0;
                    n_exam  = eis_pkg::EXAM_NONE;
                    n_phase = eis_pkg::PH_NC;
                end
            end
            eis_pkg::OP_EXAM: begin
                n_exam = (i_item.exam_code <= eis_pkg::EXAM_FLUORO) ?
                         i_item.exam_code : eis_pkg::EXAM_NONE;
                if (r_phase == eis_pkg::PH_IDLE) begin
                    cmd  = eis_pkg::CMD_WRITE_EXAM;
                    resp = eis_pkg::RESP_ACK;
                end else if (r_phase != eis_pkg::PH_NC) begin
                    resp = eis_pkg::RESP_NACK;
                end
            end
            eis_pkg::OP_STATUS: begin
                // Readiness and timeout are checked on every report while preparing.
                n_dose = i_item.dose_reading;
                if (r_phase == eis_pkg::PH_PREPING) begin
                    if (geo_ready && xray_ready) begin
                        n_phase = eis_pkg::PH_PREPD;
                    end else if (prep_elapsed >= timeout_ext) begin
                        cmd     = eis_pkg::CMD_DISARM;
                        n_en    = 1'b0;
                        n_phase = eis_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        // Button events drive the prepare and acquire transitions.
        if (bev != eis_pkg::BEV_NONE) begin
            if (i_item.button_id == eis_pkg::BTN_PREPARE) begin
                if (r_phase == eis_pkg::PH_IDLE && bev == eis_pkg::BEV_PRESS &&
                    r_exam != eis_pkg::EXAM_NONE) begin
                    cmd      = eis_pkg::CMD_ARM;
                    n_pstart = r_ms;
                    n_phase  = eis_pkg::PH_PREPING;
                end else if (r_phase == eis_pkg::PH_PREPING &&
                             bev == eis_pkg::BEV_RELEASE) begin
                    cmd     = eis_pkg::CMD_DISARM;
                    n_en    = 1'b0;
                    n_phase = eis_pkg::PH_IDLE;
                end
            end else begin
                if (r_phase == eis_pkg::PH_PREPD && bev == eis_pkg::BEV_PRESS &&
                    r_exam != eis_pkg::EXAM_NONE) begin
                    n_en    = 1'b1;
                    n_phase = eis_pkg::PH_ACQ;
                end else if (r_phase == eis_pkg::PH_ACQ &&
                             bev == eis_pkg::BEV_RELEASE) begin
                    n_en    = 1'b0;
                    resp    = eis_pkg::RESP_DOSE;
                    dose_o  = r_dose;
                    n_exam  = eis_pkg::EXAM_NONE;
                    cmd     = eis_pkg::CMD_WRITE_EXAM;
                    n_phase = eis_pkg::PH_IDLE;
                end
            end
        end
    end

    // Result fields, lamps taken from the state after the step.
    always_comb begin
        o_result.host_response   = resp;
        o_result.dose_out        = dose_o;
        o_result.device_command  = cmd;
        o_result.exam_type_out   = n_exam;
        o_result.exposure_enable = n_en;
        o_result.led_idle        = (n_phase == eis_pkg::PH_IDLE) &&
                                   (n_exam == eis_pkg::EXAM_NONE);
        o_result.led_prepared    = ((n_phase == eis_pkg::PH_IDLE) &&
                                    (n_exam != eis_pkg::EXAM_NONE)) ||
                                   (n_phase == eis_pkg::PH_PREPING) ||
                                   (n_phase == eis_pkg::PH_PREPD);
        o_result.led_acquiring   = (n_phase == eis_pkg::PH_ACQ);
        o_result.phase           = eis_pkg::phase_code(n_phase);
    end

    // State registers advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= eis_pkg::PH_NC;
            r_exam   <= eis_pkg::EXAM_NONE;
            r_ms     <= '0;
            r_pstart <= '0;
            r_last   <= '0;
            r_stable <= 2'b11;
            r_dose   <= '0;
            r_en     <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_exam   <= n_exam;
            r_ms     <= n_ms;
            r_pstart <= n_pstart;
            r_last   <= n_last;
            r_stable <= n_stable;
            r_dose   <= n_dose;
            r_en     <= n_en;
        end
    end

endmodule

### sv/exposure_interlock_sequencer_top.sv
// Top level of the exposure interlock sequencer: channels, configuration and result register.
//
// Usage: each input item is one event (millisecond tick, button level change,
// host connect or disconnect, exam type request, or device status report),
// offered with i_in_valid and taken at a clock edge where o_in_stall is low.
// Every item yields exactly one result item on the output channel, offered with
// o_out_valid and taken at an edge where i_out_stall is low.
// An item taken into the input register has its state update and result
// captured in the result register and offered once the result register is
// free or being emptied. Throughput is one item per cycle while the receiver
// does not stall; the state update of the sequencer is the only loop.
// When the receiver stalls, the result register holds its item; the input
// register keeps one more item and o_in_stall rises only when both are full.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must do so only while no item is in flight, which the block does not enforce.
// Reset (i_rst_n low, synchronous) empties both registers, returns the phase
// to not connected, the exam to none, clears the time base, the dose and the
// exposure enable, and loads the default configuration.
module exposure_interlock_sequencer_top #(
    parameter int unsigned TIME_WIDTH = eis_pkg::TimeWidthDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [eis_pkg::OpWidth-1:0]       i_operation,
    input  logic                              i_button_id,
    input  logic                              i_button_level,
    input  logic [eis_pkg::ExamWidth-1:0]     i_exam_code,
    input  logic [eis_pkg::ByteWidth-1:0]     i_geo_status,
    input  logic [eis_pkg::ByteWidth-1:0]     i_xray_status,
    input  logic [eis_pkg::ByteWidth-1:0]     i_dose_reading,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [eis_pkg::RespWidth-1:0]     o_host_response,
    output logic [eis_pkg::ByteWidth-1:0]     o_dose_out,
    output logic [eis_pkg::CmdWidth-1:0]      o_device_command,
    output logic [eis_pkg::ExamWidth-1:0]     o_exam_type_out,
    output logic                              o_exposure_enable,
    output logic                              o_led_idle,
    output logic                              o_led_prepared,
    output logic                              o_led_acquiring,
    output logic [eis_pkg::PhaseWidth-1:0]    o_phase,
    // Configuration port
    input  logic                              i_cfg_we,
    input  logic [eis_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  logic [eis_pkg::MsWidth-1:0]       i_cfg_data
);

    logic             r_in_valid;
    eis_pkg::t_item   r_in;
    logic             r_out_valid;
    eis_pkg::t_result r_out;
    eis_pkg::t_cfg    r_cfg;
    eis_pkg::t_result step_result;
    logic             step;
    logic             in_take;

    // An item moves on when the result register is free or being emptied.
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= eis_pkg::DEBOUNCE_RESET;
            r_cfg.prep_limit_ms <= eis_pkg::TIMEOUT_RESET;
            r_cfg.ready_mask    <= eis_pkg::MASK_RESET;
            r_cfg.ready_value   <= eis_pkg::VALUE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eis_pkg::CFG_DEBOUNCE: r_cfg.debounce_ms   <= i_cfg_data;
                eis_pkg::CFG_TIMEOUT:  r_cfg.prep_limit_ms <= i_cfg_data;
                eis_pkg::CFG_MASK:     r_cfg.ready_mask  <= i_cfg_data[eis_pkg::ByteWidth-1:0];
                eis_pkg::CFG_VALUE:    r_cfg.ready_value <= i_cfg_data[eis_pkg::ByteWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation    <= i_operation;
            r_in.button_id    <= i_button_id;
            r_in.button_level <= i_button_level;
            r_in.exam_code    <= i_exam_code;
            r_in.geo_status   <= i_geo_status;
            r_in.xray_status  <= i_xray_status;
            r_in.dose_reading <= i_dose_reading;
        end
    end

    // Sequencer state and step logic.
    eis_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_host_response   = r_out.host_response;
    assign o_dose_out        = r_out.dose_out;
    assign o_device_command  = r_out.device_command;
    assign o_exam_type_out   = r_out.exam_type_out;
    assign o_exposure_enable = r_out.exposure_enable;
    assign o_led_idle        = r_out.led_idle;
    assign o_led_prepared    = r_out.led_prepared;
    assign o_led_acquiring   = r_out.led_acquiring;
    assign o_phase           = r_out.phase;

endmodule

### verif/tb_top.sv
// Self-checking testbench of the exposure interlock sequencer: directed opening, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TIME_W = eis_pkg::TimeWidthDefault;
    localparam int unsigned MS_W   = eis_pkg::MsWidth;
    localparam int unsigned BYTE_W = eis_pkg::ByteWidth;
    localparam int unsigned EXAM_W = eis_pkg::ExamWidth;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CAP     = 12;
    localparam int DRAIN_CYCLES   = 4;

    // Codes that the package leaves unnamed.
    localparam logic [eis_pkg::OpWidth-1:0]   OP_SPARE_LO   = 3'd6;
    localparam logic [eis_pkg::OpWidth-1:0]   OP_SPARE_HI   = 3'd7;
    localparam logic [EXAM_W-1:0]             EXAM_SINGLE   = 3'd0;
    localparam logic [EXAM_W-1:0]             EXAM_CODE_MAX = 3'd7;
    localparam logic                          BTN_ACQUIRE   = ~eis_pkg::BTN_PREPARE;

    // Mirror of the sequencer: state, register copies and the items still owed by the block.
    class interlock_tracker;
        logic [MS_W-1:0]                     debounce_ms;
        logic [MS_W-1:0]                     timeout_ms;
        logic [BYTE_W-1:0]                   rdy_mask;
        logic [BYTE_W-1:0]                   rdy_value;
        logic [eis_pkg::PhaseWidth-1:0]      phase;
        logic [EXAM_W-1:0]                   exam;
        logic [TIME_W-1:0]                   now_ms;
        logic [TIME_W-1:0]                   prep_start_ms;
        logic [TIME_W-1:0]                   accept_ms[2];
        logic                                level[2];
        logic [BYTE_W-1:0]                   held_dose;
        logic                                enable;
        eis_pkg::t_result                    due_outcomes[$];
        int n_events, n_checked, n_errors;
        int n_acquisitions, n_dose_reports, n_timeouts;

        function new();
            debounce_ms   = eis_pkg::DEBOUNCE_RESET;
            timeout_ms    = eis_pkg::TIMEOUT_RESET;
            rdy_mask      = eis_pkg::MASK_RESET;
            rdy_value     = eis_pkg::VALUE_RESET;
            phase         = eis_pkg::PHASE_NC;
            exam          = eis_pkg::EXAM_NONE;
            now_ms        = '0;
            prep_start_ms = '0;
            accept_ms[0]  = '0;
            accept_ms[1]  = '0;
            level[0]      = eis_pkg::LVL_RELEASED;
            level[1]      = eis_pkg::LVL_RELEASED;
            held_dose     = '0;
            enable        = 1'b0;
            n_events       = 0;
            n_checked      = 0;
            n_errors       = 0;
            n_acquisitions = 0;
            n_dose_reports = 0;
            n_timeouts     = 0;
        endfunction

        function void write_register(input logic [eis_pkg::CfgIdxWidth-1:0] idx,
                                     input logic [MS_W-1:0] data);
            case (idx)
                eis_pkg::CFG_DEBOUNCE: debounce_ms = data;
                eis_pkg::CFG_TIMEOUT:  timeout_ms  = data;
                eis_pkg::CFG_MASK:     rdy_mask    = data[BYTE_W-1:0];
                eis_pkg::CFG_VALUE:    rdy_value   = data[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit device_ready(input logic [BYTE_W-1:0] status);
            return (status & rdy_mask) == rdy_value;
        endfunction

        // Advance the sequencer by one accepted item and queue the result it must produce.
        function void note_event(input eis_pkg::t_item it);
            eis_pkg::t_result  r;
            eis_pkg::t_bev     ev;
            logic              b;
            logic [TIME_W-1:0] elapsed;
            b = it.button_id;
            ev = eis_pkg::BEV_NONE;
            r.host_response  = eis_pkg::RESP_NONE;
            r.dose_out       = '0;
            r.device_command = eis_pkg::CMD_NONE;
            case (it.operation)
                eis_pkg::OP_TICK: now_ms = now_ms + TIME_W'(1);
                eis_pkg::OP_BUTTON: begin
                    // Debounce: a sample counts only once the window has passed.
                    elapsed = now_ms - accept_ms[b];
                    if (elapsed > TIME_W'(debounce_ms)) begin
                        accept_ms[b] = now_ms;
                        if (it.button_level == eis_pkg::LVL_PRESSED &&
                            level[b] == eis_pkg::LVL_RELEASED) begin
                            level[b] = eis_pkg::LVL_PRESSED;
                            ev = eis_pkg::BEV_PRESS;
                        end else if (it.button_level == eis_pkg::LVL_RELEASED &&
                                     level[b] == eis_pkg::LVL_PRESSED) begin
                            level[b] = eis_pkg::LVL_RELEASED;
                            ev = eis_pkg::BEV_RELEASE;
                        end
                    end
                end
                eis_pkg::OP_CONNECT: begin
                    if (phase == eis_pkg::PHASE_NC) begin
                        r.host_response = eis_pkg::RESP_CONNECT;
                        phase = eis_pkg::PHASE_IDLE;
                    end
                end
                eis_pkg::OP_DISCONNECT: begin
                    if (phase != eis_pkg::PHASE_NC) begin
                        enable = 1'b0;
                        exam = eis_pkg::EXAM_NONE;
                        phase = eis_pkg::PHASE_NC;
                    end
                end
                eis_pkg::OP_EXAM: begin
                    // The exam is stored in every phase; only idle accepts the request.
                    exam = (it.exam_code <= eis_pkg::EXAM_FLUORO) ? it.exam_code :
                                                                   eis_pkg::EXAM_NONE;
                    if (phase == eis_pkg::PHASE_IDLE) begin
                        r.device_command = eis_pkg::CMD_WRITE_EXAM;
                        r.host_response = eis_pkg::RESP_ACK;
                    end else if (phase != eis_pkg::PHASE_NC) begin
                        r.host_response = eis_pkg::RESP_NACK;
                    end
                end
                eis_pkg::OP_STATUS: begin
                    held_dose = it.dose_reading;
                    if (phase == eis_pkg::PHASE_PREPING) begin
                        elapsed = now_ms - prep_start_ms;
                        if (device_ready(it.geo_status) && device_ready(it.xray_status)) begin
                            phase = eis_pkg::PHASE_PREPD;
                        end else if (elapsed >= TIME_W'(timeout_ms)) begin
                            r.device_command = eis_pkg::CMD_DISARM;
                            enable = 1'b0;
                            phase = eis_pkg::PHASE_IDLE;
                            n_timeouts++;
                        end
                    end
                end
                default: ;
            endcase

            // Debounced button events move the exposure sequence.
            if (ev != eis_pkg::BEV_NONE) begin
                if (b == eis_pkg::BTN_PREPARE) begin
                    if (phase == eis_pkg::PHASE_IDLE && ev == eis_pkg::BEV_PRESS &&
                        exam != eis_pkg::EXAM_NONE) begin
                        r.device_command = eis_pkg::CMD_ARM;
                        prep_start_ms = now_ms;
                        phase = eis_pkg::PHASE_PREPING;
                    end else if (phase == eis_pkg::PHASE_PREPING &&
                                 ev == eis_pkg::BEV_RELEASE) begin
                        r.device_command = eis_pkg::CMD_DISARM;
                        enable = 1'b0;
                        phase = eis_pkg::PHASE_IDLE;
                    end
                end else begin
                    if (phase == eis_pkg::PHASE_PREPD && ev == eis_pkg::BEV_PRESS &&
                        exam != eis_pkg::EXAM_NONE) begin
                        enable = 1'b1;
                        phase = eis_pkg::PHASE_ACQ;
                        n_acquisitions++;
                    end else if (phase == eis_pkg::PHASE_ACQ &&
                                 ev == eis_pkg::BEV_RELEASE) begin
                        enable = 1'b0;
                        r.host_response = eis_pkg::RESP_DOSE;
                        r.dose_out = held_dose;
                        exam = eis_pkg::EXAM_NONE;
                        r.device_command = eis_pkg::CMD_WRITE_EXAM;
                        phase = eis_pkg::PHASE_IDLE;
                        n_dose_reports++;
                    end
                end
            end

            r.exam_type_out   = exam;
            r.exposure_enable = enable;
            r.led_idle        = (phase == eis_pkg::PHASE_IDLE && exam == eis_pkg::EXAM_NONE);
            r.led_prepared    = (phase == eis_pkg::PHASE_IDLE && exam != eis_pkg::EXAM_NONE) ||
                                phase == eis_pkg::PHASE_PREPING ||
                                phase == eis_pkg::PHASE_PREPD;
            r.led_acquiring   = (phase == eis_pkg::PHASE_ACQ);
            r.phase           = phase;
            due_outcomes.push_back(r);
            n_events++;
        endfunction

        function void check_field(input string name, input logic [BYTE_W-1:0] want,
                                  input logic [BYTE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        // Compare one result item with the oldest outstanding one.
        function void check_outcome(input eis_pkg::t_result got);
            eis_pkg::t_result want;
            if (due_outcomes.size() == 0) begin
                $error("Result item arrived with nothing outstanding");
                n_errors++;
                return;
            end
            want = due_outcomes.pop_front();
            n_checked++;
            check_field("host_response", BYTE_W'(want.host_response),
                        BYTE_W'(got.host_response));
            check_field("dose_out", want.dose_out, got.dose_out);
            check_field("device_command", BYTE_W'(want.device_command),
                        BYTE_W'(got.device_command));
            check_field("exam_type_out", BYTE_W'(want.exam_type_out),
                        BYTE_W'(got.exam_type_out));
            check_field("exposure_enable", BYTE_W'(want.exposure_enable),
                        BYTE_W'(got.exposure_enable));
            check_field("led_idle", BYTE_W'(want.led_idle), BYTE_W'(got.led_idle));
            check_field("led_prepared", BYTE_W'(want.led_prepared),
                        BYTE_W'(got.led_prepared));
            check_field("led_acquiring", BYTE_W'(want.led_acquiring),
                        BYTE_W'(got.led_acquiring));
            check_field("phase", BYTE_W'(want.phase), BYTE_W'(got.phase));
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [eis_pkg::OpWidth-1:0]         i_operation = '0;
    logic                                i_button_id = 1'b0;
    logic                                i_button_level = 1'b0;
    logic [EXAM_W-1:0]                   i_exam_code = '0;
    logic [BYTE_W-1:0]                   i_geo_status = '0;
    logic [BYTE_W-1:0]                   i_xray_status = '0;
    logic [BYTE_W-1:0]                   i_dose_reading = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [eis_pkg::RespWidth-1:0]       o_host_response;
    logic [BYTE_W-1:0]                   o_dose_out;
    logic [eis_pkg::CmdWidth-1:0]        o_device_command;
    logic [EXAM_W-1:0]                   o_exam_type_out;
    logic                                o_exposure_enable;
    logic                                o_led_idle;
    logic                                o_led_prepared;
    logic                                o_led_acquiring;
    logic [eis_pkg::PhaseWidth-1:0]      o_phase;
    logic                                i_cfg_we = 1'b0;
    logic [eis_pkg::CfgIdxWidth-1:0]     i_cfg_index = '0;
    logic [MS_W-1:0]                     i_cfg_data = '0;

    interlock_tracker  tracker;
    eis_pkg::t_result  seen;
    int                burst_left = 0;
    int                quiet_cycles = 0;
    int                stall_mode = 0;
    int                stall_run = 0;
    int                n_settings = 0;

    exposure_interlock_sequencer_top #(
        .TIME_WIDTH(TIME_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_button_id       (i_button_id),
        .i_button_level    (i_button_level),
        .i_exam_code       (i_exam_code),
        .i_geo_status      (i_geo_status),
        .i_xray_status     (i_xray_status),
        .i_dose_reading    (i_dose_reading),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_host_response   (o_host_response),
        .o_dose_out        (o_dose_out),
        .o_device_command  (o_device_command),
        .o_exam_type_out   (o_exam_type_out),
        .o_exposure_enable (o_exposure_enable),
        .o_led_idle        (o_led_idle),
        .o_led_prepared    (o_led_prepared),
        .o_led_acquiring   (o_led_acquiring),
        .o_phase           (o_phase),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Receiver stall: runs of free flow, light stalling and heavy stalling.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run <= $urandom_range(8, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 5) != 0);
        endcase
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.host_response   = o_host_response;
            seen.dose_out        = o_dose_out;
            seen.device_command  = o_device_command;
            seen.exam_type_out   = o_exam_type_out;
            seen.exposure_enable = o_exposure_enable;
            seen.led_idle        = o_led_idle;
            seen.led_prepared    = o_led_prepared;
            seen.led_acquiring   = o_led_acquiring;
            seen.phase           = o_phase;
            tracker.check_outcome(seen);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic eis_pkg::t_item random_item(input logic [eis_pkg::OpWidth-1:0] op);
        eis_pkg::t_item it;
        it = eis_pkg::t_item'($urandom);
        it.operation = op;
        return it;
    endfunction

    // Status byte that is (or most likely is not) ready under the current mask and value.
    function automatic logic [BYTE_W-1:0] status_byte(input bit ready);
        logic [BYTE_W-1:0] s;
        s = BYTE_W'($urandom);
        if (ready) begin
            s = (s & ~tracker.rdy_mask) | (tracker.rdy_value & tracker.rdy_mask);
        end
        return s;
    endfunction

    // Offer one item, with bursts and random gaps, and hold it until it is taken.
    task automatic send(input eis_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_operation    <= it.operation;
        i_button_id    <= it.button_id;
        i_button_level <= it.button_level;
        i_exam_code    <= it.exam_code;
        i_geo_status   <= it.geo_status;
        i_xray_status  <= it.xray_status;
        i_dose_reading <= it.dose_reading;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_event(it);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.due_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [eis_pkg::CfgIdxWidth-1:0] idx,
                             input logic [MS_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_register(idx, data);
    endtask

    task automatic load_settings(input logic [MS_W-1:0] db, input logic [MS_W-1:0] to,
                                 input logic [BYTE_W-1:0] mask,
                                 input logic [BYTE_W-1:0] val);
        drain();
        write_reg(eis_pkg::CFG_DEBOUNCE, db);
        write_reg(eis_pkg::CFG_TIMEOUT, to);
        write_reg(eis_pkg::CFG_MASK, MS_W'(mask));
        write_reg(eis_pkg::CFG_VALUE, MS_W'(val));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic ticks(input int n);
        repeat (n) send(random_item(eis_pkg::OP_TICK));
    endtask

    // Button level change; optionally tick (up to SETTLE_CAP) until the debounce window has passed.
    task automatic button_event(input logic b, input logic lvl, input bit wait_window);
        logic [TIME_W-1:0] elapsed;
        eis_pkg::t_item    it;
        int                n;
        n = 0;
        elapsed = tracker.now_ms - tracker.accept_ms[b];
        while (wait_window && elapsed <= TIME_W'(tracker.debounce_ms) && n < SETTLE_CAP) begin
            send(random_item(eis_pkg::OP_TICK));
            elapsed = tracker.now_ms - tracker.accept_ms[b];
            n++;
        end
        it = random_item(eis_pkg::OP_BUTTON);
        it.button_id = b;
        it.button_level = lvl;
        send(it);
    endtask

    task automatic request_exam(input logic [EXAM_W-1:0] code);
        eis_pkg::t_item it;
        it = random_item(eis_pkg::OP_EXAM);
        it.exam_code = code;
        send(it);
    endtask

    task automatic report_bytes(input logic [BYTE_W-1:0] geo, input logic [BYTE_W-1:0] xr,
                                input logic [BYTE_W-1:0] dose);
        eis_pkg::t_item it;
        it = random_item(eis_pkg::OP_STATUS);
        it.geo_status = geo;
        it.xray_status = xr;
        it.dose_reading = dose;
        send(it);
    endtask

    // Status report: mostly both devices ready, otherwise one or both random.
    task automatic report_random();
        bit both;
        both = ($urandom_range(0, 3) != 0);
        report_bytes(status_byte(both || $urandom_range(0, 1) == 0), status_byte(both),
                     BYTE_W'($urandom));
    endtask

    // One exposure attempt with random timing, content and disturbances.
    task automatic exposure_cycle();
        int n;
        if ($urandom_range(0, 15) == 0) drain();
        if (tracker.phase == eis_pkg::PHASE_NC) send(random_item(eis_pkg::OP_CONNECT));
        if ($urandom_range(0, 9) == 0) send(eis_pkg::t_item'($urandom));
        // Let go of any button still held from the previous attempt.
        if (tracker.level[eis_pkg::BTN_PREPARE] == eis_pkg::LVL_PRESSED) begin
            button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_RELEASED, 1'b1);
        end
        if (tracker.level[BTN_ACQUIRE] == eis_pkg::LVL_PRESSED) begin
            button_event(BTN_ACQUIRE, eis_pkg::LVL_RELEASED, 1'b1);
        end
        if ($urandom_range(0, 4) != 0) begin
            request_exam(EXAM_W'($urandom_range(EXAM_SINGLE, eis_pkg::EXAM_FLUORO)));
        end else begin
            request_exam(EXAM_W'($urandom_range(eis_pkg::EXAM_NONE, EXAM_CODE_MAX)));
        end
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_PRESSED, $urandom_range(0, 9) != 0);
        // Status reports until the devices are ready, time runs out or we give up.
        n = $urandom_range(1, 4);
        while (n > 0 && tracker.phase == eis_pkg::PHASE_PREPING) begin
            ticks($urandom_range(0, 4));
            report_random();
            n--;
        end
        // Now and then disturb the flow in the middle.
        case ($urandom_range(0, 11))
            0:       request_exam(EXAM_W'($urandom_range(EXAM_SINGLE, EXAM_CODE_MAX)));
            1:       send(eis_pkg::t_item'($urandom));
            2:       button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_RELEASED, 1'b1);
            default: ;
        endcase
        button_event(BTN_ACQUIRE, eis_pkg::LVL_PRESSED, $urandom_range(0, 9) != 0);
        ticks($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) report_random();
        button_event(BTN_ACQUIRE, eis_pkg::LVL_RELEASED, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) == 0) send(random_item(eis_pkg::OP_DISCONNECT));
    endtask

    task automatic run_random(input int upto);
        while (tracker.n_events < upto) exposure_cycle();
    endtask

    // Main sequence.
    initial begin
        eis_pkg::t_item    it;
        logic [BYTE_W-1:0] mask;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening with a short window and a short timeout.
        load_settings(16'd0, 16'd2, 8'h0F, 8'h02);
        it = '1;
        it.operation = OP_SPARE_HI;
        send(it);
        it = '0;
        it.operation = OP_SPARE_LO;
        send(it);
        request_exam(eis_pkg::EXAM_FLUORO);
        send(random_item(eis_pkg::OP_DISCONNECT));
        send(random_item(eis_pkg::OP_CONNECT));
        send(random_item(eis_pkg::OP_CONNECT));
        request_exam(EXAM_CODE_MAX);
        // Prepare press without an exam, the same level again, then a change inside the window.
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_PRESSED, 1'b1);
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_PRESSED, 1'b1);
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_RELEASED, 1'b0);
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_RELEASED, 1'b1);
        request_exam(EXAM_SINGLE);
        button_event(eis_pkg::BTN_PREPARE, eis_pkg::LVL_PRESSED, 1'b1);
        request_exam(eis_pkg::EXAM_FLUORO);
        // Devices not ready: first inside the timeout, then past it.
        report_bytes('0, '1, '0);
        ticks(2);
        report_bytes('1, '0, '1);
        send(random_item(eis_pkg::OP_DISCONNECT));

        // Random traffic under a series of register settings, extremes included.
        load_settings(16'd3, 16'd0, 8'h0F, 8'h02);
        run_random(180);
        mask = BYTE_W'($urandom);
        load_settings(16'd2, 16'd8, mask, mask & BYTE_W'($urandom));
        run_random(350);
        load_settings(16'hFFFF, 16'd3, 8'hF0, 8'h30);
        run_random(430);
        load_settings(16'd1, 16'd20, 8'h00, 8'h00);
        run_random(610);
        load_settings(16'd0, 16'hFFFF, 8'hFF, 8'hFF);
        run_random(790);
        mask = BYTE_W'($urandom);
        load_settings(MS_W'($urandom_range(0, 4)), MS_W'($urandom_range(0, 30)), mask,
                      BYTE_W'($urandom));
        run_random(975);

        drain();
        $display("Checked %0d results from %0d items under %0d register settings.",
                 tracker.n_checked, tracker.n_events, n_settings);
        $display("Acquisitions: %0d, dose reports: %0d, preparation timeouts: %0d.",
                 tracker.n_acquisitions, tracker.n_dose_reports, tracker.n_timeouts);
        if (tracker.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/eis_pkg.sv
sv/eis_core.sv
sv/exposure_interlock_sequencer_top.sv
verif/tb_top.sv
